### hdl/lphi_pkg.sv
// shared types and constants for the linear probing hash insert block
// no dependencies
package lphi_pkg;

  localparam int TableSlotsDefault = 500;
  localparam int KeyWidth          = 30;
  localparam int SlotWidth         = 9;
  localparam int TotalWidth        = 24;
  localparam int ModeWidth         = 2;
  localparam int CfgIndexWidth     = 1;

  localparam logic [ModeWidth-1:0] ModeDivision = 2'd0;
  localparam logic [ModeWidth-1:0] ModeFolding  = 2'd1;
  localparam logic [ModeWidth-1:0] ModeMidSq    = 2'd2;

  localparam logic [CfgIndexWidth-1:0] RegHashMode     = 1'b0;
  localparam logic [CfgIndexWidth-1:0] RegSearchNumber = 1'b1;

  localparam logic [TotalWidth-1:0] TotalMax = 24'hFFFFFF;
  localparam logic [3:0] MixFactor = 4'd15;

  typedef struct packed {
    logic                kind;
    logic [KeyWidth-1:0] student_number;
    logic [7:0]          separator_char;
    logic [7:0]          second_name_char;
    logic [7:0]          third_name_char;
    logic [7:0]          fifth_name_char;
    logic [7:0]          tenth_name_char;
  } cmd_t;

  typedef struct packed {
    logic [SlotWidth-1:0]  slot_index;
    logic [SlotWidth-1:0]  probe_count;
    logic                  table_full;
    logic                  key_matched;
    logic [TotalWidth-1:0] probe_total;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture item, start digit split
    logic digit_step; // peel one decimal digit
    logic square;     // square the mid-square sum
    logic len_step;   // count one digit of the square
    logic home_start; // start reduction of hash value
    logic home_step;  // one subtract step of reduction
    logic clr_step;   // clear one memory word
    logic rd;         // read occupancy at probe index
    logic advance;    // step probe index
    logic write;      // mark slot, update total
    logic finish;     // drive result
    logic clr_done;   // clear total, drive zero result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic digits_done;
    logic len_done;
    logic home_done;
    logic clr_last;
    logic occupied;
    logic wrapped;
  } sts_t;

endpackage

### hdl/lphi_ctrl.sv
// controller state machine for the linear probing hash insert block
// depends on lphi_pkg
module lphi_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            kind,
  input  lphi_pkg::sts_t  sts,
  output lphi_pkg::ctl_t  ctl,
  output logic            busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIGITS, S_SQUARE, S_LEN, S_HOME, S_READ, S_CHECK, S_WRITE,
    S_CLEAR, S_INIT
  } state_t;

  state_t state;

  // sequencing: digit split, square, digit count, reduction, then read, check, and step or place; clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      unique case (state)
        S_IDLE:   if (start) state <= kind ? S_CLEAR : S_DIGITS;
        S_DIGITS: if (sts.digits_done) state <= S_SQUARE;
        S_SQUARE: state <= S_LEN;
        S_LEN:    if (sts.len_done) state <= S_HOME;
        S_HOME:   if (sts.home_done) state <= S_READ;
        S_READ:   state <= S_CHECK;
        S_CHECK:  state <= (sts.occupied && !sts.wrapped) ? S_READ : S_WRITE;
        S_WRITE:  state <= S_IDLE;
        S_CLEAR:  if (sts.clr_last) state <= S_IDLE;
        S_INIT:   if (sts.clr_last) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // the clearing pass after reset gives no result, a clear transaction does
  always_comb begin
    ctl = '0;
    ctl.load       = (state == S_IDLE) && start && !kind;
    ctl.digit_step = (state == S_DIGITS);
    ctl.square     = (state == S_SQUARE);
    ctl.len_step   = (state == S_LEN) && !sts.len_done;
    ctl.home_start = (state == S_LEN) && sts.len_done;
    ctl.home_step  = (state == S_HOME);
    ctl.rd         = (state == S_READ);
    ctl.advance    = (state == S_CHECK) && sts.occupied;
    ctl.write      = (state == S_WRITE);
    ctl.finish     = (state == S_WRITE);
    ctl.clr_step   = (state == S_CLEAR) || (state == S_INIT);
    ctl.clr_done   = (state == S_CLEAR) && sts.clr_last;
  end

  assign busy = (state != S_IDLE);

endmodule

### hdl/lphi_dp.sv
// datapath: hash, probe index, occupancy memory, running total
// depends on lphi_pkg
module lphi_dp #(
  parameter int TABLE_SLOTS = lphi_pkg::TableSlotsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lphi_pkg::cmd_t                      cmd,
  input  logic [lphi_pkg::ModeWidth-1:0]      hash_mode,
  input  logic [lphi_pkg::KeyWidth-1:0]       search_number,
  input  lphi_pkg::ctl_t                      ctl,
  output lphi_pkg::sts_t                      sts,
  output lphi_pkg::result_t                   result,
  output logic                                result_valid
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int PW = $clog2(TABLE_SLOTS + 1);
  localparam int SW = lphi_pkg::SlotWidth;
  localparam int TW = lphi_pkg::TotalWidth;
  localparam logic [IW-1:0] LastSlot = IW'(TABLE_SLOTS - 1);
  localparam logic [19:0] SlotsW = 20'(TABLE_SLOTS);

  // occupancy memory, cleared by a sweep
  logic mem [TABLE_SLOTS];
  logic rd_bit;
  logic [IW-1:0] clr_addr;

  logic [lphi_pkg::KeyWidth-1:0] rest;
  logic [3:0]  dcount;
  logic [6:0]  fold_sum;
  logic [11:0] mix_sum;
  logic [23:0] len_val, len_q;
  logic [23:0] sq_pow [8];
  logic [4:0]  len;
  logic [2:0]  drop, mid_hi_ix;
  logic [23:0] mid_val;
  logic [19:0] hval;
  logic [IW-1:0] home, idx;
  logic [PW-1:0] probes;
  logic [TW-1:0] total;
  logic matched;
  logic [lphi_pkg::KeyWidth-1:0] rest_q;
  logic [3:0] rest_r;
  logic [10:0] byte_sum;
  logic [IW-1:0] idx_inc;
  logic [TW:0] t1, t2;
  logic [TW-1:0] t1s;
  logic [SW-1:0] pc_out;

  // digit split: divide by ten as multiply by reciprocal
  always_comb begin
    rest_q = lphi_pkg::KeyWidth'((64'(rest) * 64'd3435973837) >> 35);
    rest_r = 4'(rest - lphi_pkg::KeyWidth'(rest_q * 30'd10));
  end

  assign byte_sum = 11'(cmd.separator_char) + 11'(cmd.second_name_char)
                  + 11'(cmd.third_name_char) + 11'(cmd.fifth_name_char)
                  + 11'(cmd.tenth_name_char);

  // square divided by ten, one digit per length step
  assign len_q = 24'((64'(len_val) * 64'd3435973837) >> 35);

  // mid-square digits from the kept square / 10^k values
  always_comb begin
    drop      = 3'(len - 5'd1 - (len >> 1));
    mid_hi_ix = len[0] ? drop + 3'd1 : drop + 3'd2;
    mid_val   = len[0] ? sq_pow[drop] - sq_pow[mid_hi_ix] * 24'd10
                       : sq_pow[drop] - sq_pow[mid_hi_ix] * 24'd100;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rest     <= cmd.student_number;
      dcount   <= '0;
      fold_sum <= '0;
      mix_sum  <= '0;
      matched  <= (cmd.student_number == search_number);
      hval     <= 20'(byte_sum);
    end
    if (ctl.digit_step) begin
      rest     <= rest_q;
      dcount   <= dcount + 4'd1;
      fold_sum <= fold_sum + 7'(rest_r);
      mix_sum  <= mix_sum + 12'(rest_r) * 12'(lphi_pkg::MixFactor);
    end
    if (ctl.square) begin
      sq_pow[0] <= 24'(mix_sum) * 24'(mix_sum);
      for (int k = 1; k < 8; k++) sq_pow[k] <= '0;
      len_val <= 24'(mix_sum) * 24'(mix_sum);
      len     <= 5'd1;
    end
    if (ctl.len_step) begin
      sq_pow[len[2:0]] <= len_q;
      len_val <= len_q;
      len     <= len + 5'd1;
    end
    if (ctl.home_start) begin
      case (hash_mode)
        lphi_pkg::ModeFolding: hval <= 20'(fold_sum);
        lphi_pkg::ModeMidSq:   hval <= 20'(mid_val);
        default:               hval <= hval;
      endcase
    end
    if (ctl.home_step && hval >= SlotsW) hval <= hval - SlotsW;
    if (ctl.home_step && hval < SlotsW) begin
      home   <= IW'(hval);
      idx    <= IW'(hval);
      probes <= '0;
    end
    if (ctl.advance) begin
      idx    <= idx_inc;
      probes <= probes + PW'(1);
    end
  end

  assign idx_inc = (idx == LastSlot) ? '0 : idx + IW'(1);

  // memory port
  always_ff @(posedge clk) begin
    if (ctl.clr_step) mem[clr_addr] <= 1'b0;
    else if (ctl.write) mem[idx] <= 1'b1;
    if (ctl.rd) rd_bit <= mem[idx];
  end

  // sweep address wraps to zero after the last slot
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (ctl.clr_step) clr_addr <= sts.clr_last ? '0 : clr_addr + IW'(1);
  end

  // saturating total update
  always_comb begin
    t1  = (TW+1)'(total) + (TW+1)'(probes);
    t1s = t1[TW] ? lphi_pkg::TotalMax : t1[TW-1:0];
    t2  = (TW+1)'(t1s) + (TW+1)'(idx);
    pc_out = (PW > SW && probes > PW'(511)) ? '1 : SW'(probes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.finish || (ctl.clr_done && !rst);
      if (ctl.clr_done) begin
        total  <= '0;
        result <= '0;
      end
      if (ctl.write) begin
        total <= matched ? (t2[TW] ? lphi_pkg::TotalMax : t2[TW-1:0]) : t1s;
        result.slot_index  <= SW'(idx);
        result.probe_count <= pc_out;
        result.table_full  <= rd_bit;
        result.key_matched <= matched;
        result.probe_total <= matched ? (t2[TW] ? lphi_pkg::TotalMax : t2[TW-1:0]) : t1s;
      end
    end
  end

  assign sts.digits_done = (dcount == 4'd8) && ctl.digit_step;
  assign sts.len_done    = (len_val < 24'd10);
  assign sts.home_done   = (hval < SlotsW);
  assign sts.clr_last    = (clr_addr == LastSlot);
  assign sts.occupied    = rd_bit;
  assign sts.wrapped     = rd_bit && (idx_inc == home);

endmodule

### hdl/linear_probe_hash_insert_top.sv
// Linear probing hash insert over a table of slot-occupancy bits.
// Command channel: an item is taken when start is high and busy is low.
// kind 0 inserts a record, kind 1 clears the table and the running total.
// Each item gives one result on result with result_valid high for one
// cycle; the receiver cannot stall and must take it then.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set
// hash_mode (index 0) and search_number (index 1); write them while idle.
// Insert: a split of nine decimal digits, one square, counting the digits of
// the square (one to seven), a final reduction step plus one per subtraction
// of TABLE_SLOTS (at most 2 at 500 slots), a read and a check per slot
// probed, free slot included, and one place step, which registers the result
// and its strobe. busy drops with the strobe.
// Clear sweeps the memory one word a cycle, then gives the result.
// Reset runs the same clearing pass over all TABLE_SLOTS words with no result;
// busy stays high until it ends, configuration writes are taken throughout.
// Results of a full table return the home slot with table_full set.
// Reset clears the registers to hash_mode 0 and search_number 0.
module linear_probe_hash_insert_top #(
  parameter int TABLE_SLOTS = lphi_pkg::TableSlotsDefault
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  lphi_pkg::cmd_t                        cmd,
  output lphi_pkg::result_t                     result,
  output logic                                  result_valid,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lphi_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [31:0]                           cfg_data
);

  lphi_pkg::ctl_t ctl;
  lphi_pkg::sts_t sts;
  logic [lphi_pkg::ModeWidth-1:0] hash_mode;
  logic [lphi_pkg::KeyWidth-1:0]  search_number;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode     <= lphi_pkg::ModeDivision;
      search_number <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lphi_pkg::RegHashMode:     hash_mode <= cfg_data[lphi_pkg::ModeWidth-1:0];
        lphi_pkg::RegSearchNumber: search_number <= cfg_data[lphi_pkg::KeyWidth-1:0];
        default: ;
      endcase
    end
  end

  lphi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (cmd.kind),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  lphi_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .hash_mode     (hash_mode),
    .search_number (search_number),
    .ctl           (ctl),
    .sts           (sts),
    .result        (result),
    .result_valid  (result_valid)
  );

endmodule
